>>> hw/rtl/c3cf_pkg.sv
package c3cf_pkg;

	// Frame geometry
	localparam int MAX_WIDTH = 1024;
	localparam int ADDR_W    = $clog2(MAX_WIDTH);
	localparam int WCNT_W    = ADDR_W + 1;
	localparam int FW_W      = 11;
	localparam int FH_W      = 16;
	localparam int ROW_W     = FH_W + 1;

	// Pixel and coefficient formats
	localparam int PIX_W          = 8;
	localparam int NUM_CH         = 3;
	localparam int WORD_W         = PIX_W * NUM_CH;
	localparam int COEF_W         = 16;
	localparam int COEF_FRAC_BITS = 8;
	localparam int KERN_W         = 3 * COEF_W;
	localparam int PROD_W         = PIX_W + 1 + COEF_W;
	localparam int SUM_W          = PROD_W + 4;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = KERN_W;

	localparam logic [CFG_IDX_W-1:0] REG_KERN_TOP    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_KERN_MIDDLE = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_KERN_BOTTOM = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE  = CFG_IDX_W'(5);

	// Input word kind carried in tuser
	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_DRAIN = 1'b1;

	typedef logic [WORD_W-1:0]         word_t;
	typedef logic signed [COEF_W-1:0]  coef_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [SUM_W-1:0]   sum_t;

	localparam sum_t SAT_LEVEL = sum_t'(((1 << PIX_W) - 1) << COEF_FRAC_BITS);

	// Which window borders lie inside the frame
	typedef struct packed {
		logic row_top;
		logic row_bot;
		logic col_left;
		logic col_right;
	} border_ok_t;

endpackage

>>> hw/rtl/c3cf_ram.sv
module c3cf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/conv3x3_clamped_filter.sv
// 3x3 convolution filter on a raster pixel stream, gray or three channels.
// Input stream (s_*): one word per pixel in raster order; tuser low means a
// pixel, high means a drain tick. Drain ticks inside a frame are dropped; after
// the last pixel of a frame, every word (pixel or drain) advances the window by
// one position, and frame_width+1 of them flush the last row.
// Output stream (m_*): one word per pixel position, three filtered channels
// clamped to 0..255; tlast marks the last pixel of the frame. Channels 1 and 2
// read zero in gray mode.
// Throughput: one word per clock while m_tready allows. The line stores are one dual-port
// RAM read at accept and written as the word leaves stage 1, with a bypass for the case
// where consecutive words hit the same column.
// Pipeline: after the word that completes its 3x3 neighborhood, a result passes
// the read/window, multiply and sum/clamp stages; the stream lags by
// frame_width+1 words.
// Reset: counters, window and valid flags clear; kernel reads zero, size is
// 1024x768, gray mode. Line store contents are don't-care until written.
// Stall: when m_tready is low the result register holds, the pipeline fills
// its empty stages and only then drops s_tready.
// Configuration: cfg_we writes cfg_data to register cfg_index; write only
// while the pipeline is empty.
module conv3x3_clamped_filter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [c3cf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [c3cf_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [c3cf_pkg::WORD_W-1:0]          s_tdata,  // pixel_ch0, pixel_ch1, pixel_ch2
	input  logic                                 s_tuser,  // action
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [c3cf_pkg::WORD_W-1:0]          m_tdata,  // out_ch0, out_ch1, out_ch2
	output logic                                 m_tlast   // frame_end
);

	import c3cf_pkg::*;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [KERN_W-1:0] kern_q [3];
	logic [FW_W-1:0]   width_q;
	logic [FH_W-1:0]   height_q;
	logic              color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kern_q[0] <= '0;
			kern_q[1] <= '0;
			kern_q[2] <= '0;
			width_q   <= FW_W'(1024);
			height_q  <= FH_W'(768);
			color_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KERN_TOP:     kern_q[0] <= cfg_data[KERN_W-1:0];
				REG_KERN_MIDDLE:  kern_q[1] <= cfg_data[KERN_W-1:0];
				REG_KERN_BOTTOM:  kern_q[2] <= cfg_data[KERN_W-1:0];
				REG_FRAME_WIDTH:  width_q   <= cfg_data[FW_W-1:0];
				REG_FRAME_HEIGHT: height_q  <= cfg_data[FH_W-1:0];
				REG_COLOR_MODE:   color_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Effective frame size: zero acts as one, width saturates at the line store depth
	logic [WCNT_W-1:0] w_eff;
	logic [FH_W-1:0]   h_eff;

	always_comb begin
		if (width_q == '0) begin
			w_eff = WCNT_W'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			w_eff = WCNT_W'(MAX_WIDTH);
		end else begin
			w_eff = WCNT_W'(width_q);
		end
		h_eff = (height_q == '0) ? FH_W'(1) : height_q;
	end

	// ------------------------------------------------------------------
	// Handshake: each stage moves when the one after it has room
	// ------------------------------------------------------------------
	logic valid_s1, valid_s2, valid_s3;
	logic adv1, adv2, adv3;
	logic accept, fire1;

	assign adv3     = !valid_s3 || m_tready;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign s_tready = adv1;
	assign accept   = s_tvalid && s_tready;
	assign fire1    = valid_s1 && adv2;

	// ------------------------------------------------------------------
	// Position counters, updated at accept
	// ------------------------------------------------------------------
	logic [ADDR_W-1:0] icol_q, ocol_q;
	logic [ROW_W-1:0]  irow_q;
	logic [FH_W-1:0]   orow_q;

	logic [ADDR_W-1:0] icol_pre, icol_nx, ocol_pre, ocol_nx;
	logic [ROW_W-1:0]  irow_pre, irow_nx;
	logic [FH_W-1:0]   orow_pre, orow_nx;
	logic [WCNT_W-1:0] icol_inc, ocol_inc;
	logic              in_frame, do_step, emit, last;
	border_ok_t        bord;
	word_t             pix;

	always_comb begin
		// wrap counters left past a narrowed width
		if (WCNT_W'(icol_q) >= w_eff) begin
			icol_pre = '0;
			irow_pre = irow_q + ROW_W'(1);
		end else begin
			icol_pre = icol_q;
			irow_pre = irow_q;
		end
		if (WCNT_W'(ocol_q) >= w_eff) begin
			ocol_pre = '0;
			orow_pre = orow_q + FH_W'(1);
		end else begin
			ocol_pre = ocol_q;
			orow_pre = orow_q;
		end

		in_frame = irow_pre < ROW_W'(h_eff);
		do_step  = !in_frame || (s_tuser == ACT_PIXEL);
		pix      = in_frame ? s_tdata : '0;
		emit     = (irow_pre >= ROW_W'(2)) || ((irow_pre == ROW_W'(1)) && (icol_pre != '0));

		icol_inc = WCNT_W'(icol_pre) + WCNT_W'(1);
		if (icol_inc >= w_eff) begin
			icol_nx = '0;
			irow_nx = irow_pre + ROW_W'(1);
		end else begin
			icol_nx = icol_inc[ADDR_W-1:0];
			irow_nx = irow_pre;
		end

		bord.row_top   = orow_pre != '0;
		bord.row_bot   = (ROW_W'(orow_pre) + ROW_W'(1)) < ROW_W'(h_eff);
		bord.col_left  = ocol_pre != '0;
		bord.col_right = (WCNT_W'(ocol_pre) + WCNT_W'(1)) < w_eff;
		last           = !bord.row_bot && !bord.col_right;

		ocol_inc = WCNT_W'(ocol_pre) + WCNT_W'(1);
		if (ocol_inc >= w_eff) begin
			ocol_nx = '0;
			orow_nx = orow_pre + FH_W'(1);
		end else begin
			ocol_nx = ocol_inc[ADDR_W-1:0];
			orow_nx = orow_pre;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			icol_q <= '0;
			irow_q <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (accept) begin
			if (do_step && emit && last) begin
				// frame done: restart every counter
				icol_q <= '0;
				irow_q <= '0;
				ocol_q <= '0;
				orow_q <= '0;
			end else begin
				icol_q <= do_step ? icol_nx : icol_pre;
				irow_q <= do_step ? irow_nx : irow_pre;
				ocol_q <= (do_step && emit) ? ocol_nx : ocol_pre;
				orow_q <= (do_step && emit) ? orow_nx : orow_pre;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: line store read, window, border masking
	// ------------------------------------------------------------------
	word_t             pix_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              col0_s1, emit_s1, last_s1, byp_s1;
	border_ok_t        bord_s1;
	logic [2*WORD_W-1:0] byp_data_s1;

	logic [2*WORD_W-1:0] ram_rdata;
	word_t               top_eff, mid_eff;

	// upper store in the high half, lower store in the low half
	c3cf_ram #(
		.WIDTH (2 * WORD_W),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (fire1),
		.waddr (addr_s1),
		.wdata ({mid_eff, pix_s1}),
		.re    (accept && do_step),
		.raddr (icol_pre),
		.rdata (ram_rdata)
	);

	always_comb begin
		if (byp_s1) begin
			top_eff = byp_data_s1[2*WORD_W-1:WORD_W];
			mid_eff = byp_data_s1[WORD_W-1:0];
		end else begin
			top_eff = ram_rdata[2*WORD_W-1:WORD_W];
			mid_eff = ram_rdata[WORD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv1) begin
			valid_s1 <= accept && do_step;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && do_step) begin
			pix_s1      <= pix;
			addr_s1     <= icol_pre;
			col0_s1     <= icol_pre == '0;
			emit_s1     <= emit;
			last_s1     <= last;
			bord_s1     <= bord;
			// the word leaving stage 1 writes the column this word reads
			byp_s1      <= fire1 && (addr_s1 == icol_pre);
			byp_data_s1 <= {mid_eff, pix_s1};
		end
	end

	word_t win_q [3][3];
	word_t newcol [3];
	word_t nb [3][3];
	coef_t coef [3][3];

	always_comb begin
		newcol[0] = top_eff;
		newcol[1] = mid_eff;
		newcol[2] = pix_s1;
		for (int r = 0; r < 3; r++) begin
			nb[r][0] = win_q[r][1];
			nb[r][1] = win_q[r][2];
			// a fresh row has no right neighbor column yet
			nb[r][2] = col0_s1 ? '0 : newcol[r];
		end
		// neighbors outside the frame count as zero
		for (int c = 0; c < 3; c++) begin
			if (!bord_s1.row_top) nb[0][c] = '0;
			if (!bord_s1.row_bot) nb[2][c] = '0;
		end
		for (int r = 0; r < 3; r++) begin
			if (!bord_s1.col_left)  nb[r][0] = '0;
			if (!bord_s1.col_right) nb[r][2] = '0;
		end
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				coef[r][c] = coef_t'(kern_q[r][COEF_W*c +: COEF_W]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (fire1) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
				win_q[r][2] <= newcol[r];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: 27 products, unsigned pixel times signed coefficient
	// ------------------------------------------------------------------
	prod_t prod [NUM_CH][3][3];
	prod_t prod_s2 [NUM_CH][3][3];
	logic  last_s2;

	always_comb begin
		logic [PIX_W-1:0] px;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					px = nb[r][c][PIX_W*ch +: PIX_W];
					prod[ch][r][c] = PROD_W'(signed'({1'b0, px})) * PROD_W'(coef[r][c]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= valid_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && valid_s1 && emit_s1) begin
			prod_s2 <= prod;
			last_s2 <= last_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: sum, clamp, result register
	// ------------------------------------------------------------------
	function automatic logic [PIX_W-1:0] clamp_px(sum_t s);
		if (s <= sum_t'(0)) begin
			return '0;
		end else if (s >= SAT_LEVEL) begin
			return '1;
		end else begin
			return s[COEF_FRAC_BITS +: PIX_W];
		end
	endfunction

	sum_t              sum [NUM_CH];
	logic [PIX_W-1:0]  res [NUM_CH];
	word_t             data_s3;
	logic              last_s3;

	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			sum[ch] = '0;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					sum[ch] = sum[ch] + SUM_W'(prod_s2[ch][r][c]);
				end
			end
			res[ch] = clamp_px(sum[ch]);
		end
		// gray mode: drop the color channels
		if (!color_q) begin
			res[1] = '0;
			res[2] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && valid_s2) begin
			data_s3 <= {res[2], res[1], res[0]};
			last_s3 <= last_s2;
		end
	end

	assign m_tvalid = valid_s3;
	assign m_tdata  = data_s3;
	assign m_tlast  = last_s3;

endmodule

>>> dv/conv3x3_clamped_filter_test.sv
module conv3x3_clamped_filter_test;
	import c3cf_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int RANDOM_WORDS = 1900;
	// cycles to let the pipeline settle once the last result is in
	localparam int PIPE_SLACK   = 8;

	// one word on the input stream: action in tuser, channels in tdata
	typedef struct packed {
		logic  drain;
		word_t px;
	} stream_word_t;

	// one filtered pixel as seen on the output stream
	typedef struct packed {
		logic [PIX_W-1:0] ch0;
		logic [PIX_W-1:0] ch1;
		logic [PIX_W-1:0] ch2;
		logic             frame_end;
	} filtered_px_t;

	typedef enum {KERN_SIGNED, KERN_BLUR, KERN_RAW} kern_style_t;
	typedef enum {RDY_ALWAYS, RDY_MOSTLY, RDY_SELDOM, RDY_HOLD} ready_mode_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	word_t                 s_tdata   = '0;  // pixel_ch0, pixel_ch1, pixel_ch2
	logic                  s_tuser   = ACT_PIXEL;  // action
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	word_t                 m_tdata;  // out_ch0, out_ch1, out_ch2
	logic                  m_tlast;  // frame_end

	conv3x3_clamped_filter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// Filter predictor: own copy of the registers, line stores, window and
	// the input/output raster counters.
	// ------------------------------------------------------------------
	logic [KERN_W-1:0] kern_rows [3];
	int unsigned       fw_reg;
	int unsigned       fh_reg;
	logic              color_en;

	word_t             upper_line [MAX_WIDTH];
	word_t             lower_line [MAX_WIDTH];
	word_t             win [3][3];
	int unsigned       in_col, in_row, out_col, out_row;

	stream_word_t      pending_words [$];
	filtered_px_t      expected_px [$];
	int                mismatches   = 0;
	int                random_words = 0;
	int unsigned       cycle_count  = 0;

	// out-of-range sizes: width 0 acts as 1, above the line store as its depth
	function automatic int unsigned eff_width();
		if (fw_reg == 0)
			return 1;
		return (fw_reg > MAX_WIDTH) ? MAX_WIDTH : fw_reg;
	endfunction

	function automatic int unsigned eff_height();
		return (fh_reg == 0) ? 1 : fh_reg;
	endfunction

	// weighted sum of one channel over the in-frame neighbors, clamped
	function automatic logic [PIX_W-1:0] filter_sum(input logic [8:0][WORD_W-1:0] nb,
			input logic [8:0] ok, input int ch);
		int acc;
		int pxv;
		int cf;
		acc = 0;
		for (int k = 0; k < 9; k++) begin
			if (ok[k]) begin
				pxv = int'(nb[k][PIX_W*ch +: PIX_W]);
				cf  = coef_t'(kern_rows[k/3][COEF_W*(k%3) +: COEF_W]);
				acc += pxv * cf;
			end
		end
		if (acc <= 0)
			return '0;
		if (acc >= (((1 << PIX_W) - 1) << COEF_FRAC_BITS))
			return '1;
		return PIX_W'(acc >>> COEF_FRAC_BITS);
	endfunction

	// advance the predictor by one accepted word; queue the pixel it completes
	function automatic void advance_window(input logic drain, input word_t px);
		int unsigned             w, h, ic;
		word_t                   pixv, top, mid;
		logic [8:0][WORD_W-1:0]  nb;
		logic [8:0]              ok;
		logic                    emit, last_px;
		filtered_px_t            res;

		w = eff_width();
		h = eff_height();
		// wrap lazily so that a narrower width takes effect at once
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
		end
		if (out_col >= w) begin
			out_col = 0;
			out_row++;
		end

		// inside the frame a drain is dropped; past it every word is a blank
		if (in_row < h) begin
			if (drain == ACT_DRAIN)
				return;
			pixv = px;
		end else begin
			pixv = '0;
		end

		ic   = in_col & (MAX_WIDTH - 1);
		emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);

		top = upper_line[ic];
		mid = lower_line[ic];
		upper_line[ic] = mid;
		lower_line[ic] = pixv;

		// on a row start the centered window is the old one, right column blank
		if (in_col == 0) begin
			for (int r = 0; r < 3; r++) begin
				nb[3*r]     = win[r][1];
				nb[3*r + 1] = win[r][2];
				nb[3*r + 2] = '0;
			end
		end
		for (int r = 0; r < 3; r++) begin
			win[r][0] = win[r][1];
			win[r][1] = win[r][2];
		end
		win[0][2] = top;
		win[1][2] = mid;
		win[2][2] = pixv;
		if (in_col != 0) begin
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					nb[3*r + c] = win[r][c];
		end

		in_col++;
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
		end

		if (!emit)
			return;

		// mask neighbors that fall outside the frame
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				ok[3*r + c] = !((r == 0 && out_row == 0) || (r == 2 && out_row + 1 >= h) ||
					(c == 0 && out_col == 0) || (c == 2 && out_col + 1 >= w));

		res.ch0 = filter_sum(nb, ok, 0);
		res.ch1 = color_en ? filter_sum(nb, ok, 1) : '0;
		res.ch2 = color_en ? filter_sum(nb, ok, 2) : '0;
		last_px = (out_row + 1 >= h) && (out_col + 1 >= w);
		res.frame_end = last_px;
		expected_px.push_back(res);

		if (last_px) begin
			in_col  = 0;
			in_row  = 0;
			out_col = 0;
			out_row = 0;
		end else begin
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				out_row++;
			end
		end
	endfunction

	// ------------------------------------------------------------------
	// Driver: pop words from the pending queue in bursts with random gaps;
	// hold the word while the block stalls; predict on every accepted word.
	// ------------------------------------------------------------------
	int burst_left = 0;
	int gap_left   = 0;

	always @(posedge clk) begin : drive_words
		stream_word_t nxt;
		if (s_tvalid && s_tready)
			advance_window(s_tuser, s_tdata);
		if (!s_tvalid || s_tready) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pending_words.size() != 0) begin
				nxt = pending_words.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= nxt.drain;
				s_tdata  <= nxt.px;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 40);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: check every accepted result against the oldest prediction;
	// drive tready from a pattern of stall modes that change over time.
	// ------------------------------------------------------------------
	ready_mode_t ready_mode = RDY_ALWAYS;
	int          mode_left  = 0;

	task automatic check_field(input string name, input logic [PIX_W-1:0] want,
			input logic [PIX_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : check_results
		filtered_px_t want;
		if (m_tvalid === 1'b1 && m_tready) begin
			if (expected_px.size() == 0) begin
				$error("result with no pixel pending: tdata %h tlast %b", m_tdata, m_tlast);
				mismatches++;
			end else begin
				want = expected_px.pop_front();
				check_field("out_ch0", want.ch0, m_tdata[0*PIX_W +: PIX_W]);
				check_field("out_ch1", want.ch1, m_tdata[1*PIX_W +: PIX_W]);
				check_field("out_ch2", want.ch2, m_tdata[2*PIX_W +: PIX_W]);
				check_field("frame_end", PIX_W'(want.frame_end), PIX_W'(m_tlast));
			end
		end

		if (mode_left == 0) begin
			ready_mode = ready_mode_t'($urandom_range(0, 3));
			mode_left  = (ready_mode == RDY_HOLD) ? $urandom_range(1, 24) :
				$urandom_range(16, 200);
		end else begin
			mode_left--;
		end
		case (ready_mode)
			RDY_ALWAYS: m_tready <= 1'b1;
			RDY_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
			RDY_SELDOM: m_tready <= ($urandom_range(0, 3) == 0);
			default:    m_tready <= 1'b0;
		endcase
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("conv3x3_clamped_filter test failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// wait until every word is accepted and every result has come, then settle
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_words.size() != 0 || s_tvalid || expected_px.size() != 0);
		repeat (PIPE_SLACK) @(negedge clk);
	endtask

	task automatic queue_word(input logic drain, input word_t px);
		stream_word_t sw;
		sw.drain = drain;
		sw.px    = px;
		pending_words.push_back(sw);
		random_words++;
	endtask

	// n pixels with stray drains mixed in; pause for a full drain at pause_at
	task automatic queue_pixels(input int unsigned n, input int unsigned pause_at);
		stream_word_t noise;
		for (int unsigned i = 1; i <= n; i++) begin
			if ($urandom_range(0, 7) == 0) begin
				noise.drain = ACT_DRAIN;
				noise.px    = word_t'($urandom);
				pending_words.push_back(noise);
			end
			queue_word(ACT_PIXEL, word_t'($urandom));
			if (i == pause_at)
				wait_idle();
		end
	endtask

	// flush positions past the last pixel: drains, with some pixels among them
	task automatic queue_tail(input int unsigned n);
		repeat (n)
			queue_word(($urandom_range(0, 2) == 0) ? ACT_PIXEL : ACT_DRAIN, word_t'($urandom));
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_KERN_TOP:     kern_rows[0] = val[KERN_W-1:0];
			REG_KERN_MIDDLE:  kern_rows[1] = val[KERN_W-1:0];
			REG_KERN_BOTTOM:  kern_rows[2] = val[KERN_W-1:0];
			REG_FRAME_WIDTH:  fw_reg = val[FW_W-1:0];
			REG_FRAME_HEIGHT: fh_reg = val[FH_W-1:0];
			REG_COLOR_MODE:   color_en = val[0];
			default: ;
		endcase
	endtask

	task automatic program_filter(input logic [KERN_W-1:0] top, mid, bot,
			input int unsigned w, h, input logic color);
		write_cfg(REG_KERN_TOP, CFG_DATA_W'(top));
		write_cfg(REG_KERN_MIDDLE, CFG_DATA_W'(mid));
		write_cfg(REG_KERN_BOTTOM, CFG_DATA_W'(bot));
		write_cfg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
		write_cfg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
		write_cfg(REG_COLOR_MODE, CFG_DATA_W'(color));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic coef_t rand_coef(input kern_style_t style);
		case (style)
			KERN_BLUR: return coef_t'($urandom_range(0, 72));
			KERN_RAW:  return coef_t'($urandom);
			default: begin
				if ($urandom_range(0, 9) == 0)
					return ($urandom_range(0, 1) != 0) ? coef_t'(16'h7FFF) : coef_t'(16'h8000);
				return coef_t'(int'($urandom_range(0, 768)) - 384);
			end
		endcase
	endfunction

	function automatic logic [KERN_W-1:0] rand_kernel_row(input kern_style_t style);
		return {rand_coef(style), rand_coef(style), rand_coef(style)};
	endfunction

	task automatic program_random(input int unsigned w, h, input logic color);
		kern_style_t style;
		style = kern_style_t'($urandom_range(0, 2));
		program_filter(rand_kernel_row(style), rand_kernel_row(style), rand_kernel_row(style),
			w, h, color);
	endtask

	// complete whatever frame is open: exact pixel count, then drains to the end
	task automatic finish_frame();
		int unsigned w, h, col, row, rem;
		wait_idle();
		w   = eff_width();
		h   = eff_height();
		col = in_col;
		row = in_row;
		if (col >= w) begin
			col = 0;
			row++;
		end
		rem = (row < h) ? (h - row) * w - col : 0;
		queue_pixels(rem, 0);
		wait_idle();
		while (in_col != 0 || in_row != 0 || out_col != 0 || out_row != 0) begin
			repeat (w + 1)
				queue_word(ACT_DRAIN, word_t'($urandom));
			wait_idle();
		end
	endtask

	// whole frames at one random setting, occasionally paused at a random pixel
	task automatic run_frames_phase();
		int unsigned pick, w_reg, h_reg, npx;
		pick  = $urandom_range(0, 19);
		w_reg = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(13, 64) : $urandom_range(1, 12);
		h_reg = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 8);
		program_random(w_reg, h_reg, $urandom_range(0, 1));
		repeat ($urandom_range(1, 3)) begin
			npx = eff_width() * eff_height();
			queue_pixels(npx, ($urandom_range(0, 3) == 0) ? $urandom_range(1, npx) : 0);
			queue_tail(eff_width() + 1);
		end
		wait_idle();
	endtask

	// stop inside a frame, resize while idle, then run the frame out
	task automatic run_resize_phase(input logic tall);
		int unsigned w1, rows, new_w, new_h;
		w1   = $urandom_range(3, 10);
		rows = $urandom_range(2, 3);
		program_random(w1, tall ? ((1 << FH_W) - 1) : $urandom_range(rows + 2, 8),
			$urandom_range(0, 1));
		queue_pixels(rows * w1 + $urandom_range(0, w1 - 1), 0);
		wait_idle();
		new_w = ($urandom_range(0, 1) != 0) ? w1 : $urandom_range(1, 12);
		new_h = $urandom_range(1, rows + 3);
		write_cfg(REG_FRAME_WIDTH, CFG_DATA_W'(new_w));
		write_cfg(REG_FRAME_HEIGHT, CFG_DATA_W'(new_h));
		@(posedge clk);
		cfg_we <= 1'b0;
		queue_pixels($urandom_range(0, 2 * new_w), 0);
		finish_frame();
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin : run_test
		int phase_no;

		// predictor state after reset
		kern_rows[0] = '0;
		kern_rows[1] = '0;
		kern_rows[2] = '0;
		fw_reg   = MAX_WIDTH;
		fh_reg   = 768;
		color_en = 1'b0;
		for (int i = 0; i < MAX_WIDTH; i++) begin
			upper_line[i] = '0;
			lower_line[i] = '0;
		end
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				win[r][c] = '0;
		in_col  = 0;
		in_row  = 0;
		out_col = 0;
		out_row = 0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// 3x3 color frame; kernel holds both coefficient extremes at corners
		// that get masked on the frame border. Channels are {ch2, ch1, ch0}.
		program_filter({16'h0000, 16'h0040, 16'h8000}, {16'hFFE0, 16'h0100, 16'h0020},
			{16'h0010, 16'hFFC0, 16'h7FFF}, 3, 3, 1'b1);
		queue_word(ACT_DRAIN, word_t'($urandom));  // drain inside frame: dropped
		queue_word(ACT_PIXEL, {8'd255, 8'd255, 8'd255});
		queue_word(ACT_PIXEL, {8'd0, 8'd0, 8'd0});
		queue_word(ACT_PIXEL, {8'd128, 8'd0, 8'd255});
		queue_word(ACT_DRAIN, word_t'($urandom));
		queue_word(ACT_PIXEL, {8'd1, 8'd255, 8'd0});
		queue_word(ACT_PIXEL, {8'd128, 8'd128, 8'd128});
		queue_word(ACT_PIXEL, {8'd3, 8'd2, 8'd1});
		queue_word(ACT_PIXEL, {8'd255, 8'd255, 8'd255});
		queue_word(ACT_PIXEL, {8'd0, 8'd0, 8'd0});
		queue_word(ACT_PIXEL, {8'd50, 8'd100, 8'd200});
		// flush: a pixel past the frame acts as a drain and its values drop
		queue_word(ACT_PIXEL, {8'd255, 8'd255, 8'd255});
		queue_word(ACT_DRAIN, '0);
		queue_word(ACT_PIXEL, {8'd51, 8'd34, 8'd17});
		queue_word(ACT_DRAIN, '1);
		wait_idle();

		// zero size acts as 1x1; gray mode zeroes channels 1 and 2
		program_filter('0, {16'h0000, 16'h0100, 16'h0000}, '0, 0, 0, 1'b0);
		queue_word(ACT_PIXEL, {8'hFF, 8'h5A, 8'hA5});
		queue_word(ACT_PIXEL, {8'h56, 8'h34, 8'h12});
		queue_word(ACT_DRAIN, '0);
		wait_idle();

		// widest frame: register above the line store clamps to its depth;
		// this also fills every line store entry before any resize
		program_filter(rand_kernel_row(KERN_BLUR), rand_kernel_row(KERN_BLUR),
			rand_kernel_row(KERN_BLUR), (1 << FW_W) - 1, 1, 1'b1);
		queue_pixels(MAX_WIDTH, MAX_WIDTH / 2);
		queue_tail(MAX_WIDTH + 1);
		wait_idle();

		// random phases; every eighth one resizes inside a frame
		random_words = 0;
		phase_no     = 0;
		while (random_words < RANDOM_WORDS) begin
			if (phase_no % 8 == 0)
				run_resize_phase(phase_no == 0 || $urandom_range(0, 1) != 0);
			else
				run_frames_phase();
			phase_no++;
		end

		wait_idle();
		if (mismatches == 0)
			$display("conv3x3_clamped_filter test passed");
		else
			$display("conv3x3_clamped_filter test failed");
		$finish;
	end

endmodule

>>> conv3x3_clamped_filter.f
hw/rtl/c3cf_pkg.sv
hw/rtl/c3cf_ram.sv
hw/rtl/conv3x3_clamped_filter.sv
dv/conv3x3_clamped_filter_test.sv
